@@ hdl/dpsd_pkg.sv @@
// Shared types and constants of the dual PID steer and drive controller.
// Used by dpsd_mac, dpsd_div and dual_pid_steer_drive_controller; depends on nothing.
package dpsd_pkg;

  // Field and datapath widths.
  localparam int unsigned DATA_W = 16;
  localparam int unsigned TOL_W  = 15;
  localparam int unsigned INT_W  = 32;
  localparam int unsigned TICK_W = 11;
  localparam int unsigned OPA_W  = 33;
  localparam int unsigned OPB_W  = 17;
  localparam int unsigned ACC_W  = 50;
  localparam int unsigned FRAC_W = 15;

  // Defaults of the top-level parameters.
  localparam int unsigned CENTER_COLUMN_DEF        = 320;
  localparam int unsigned INTEGRAL_RESET_LIMIT_DEF = 1000;

  // Loop output is (KP_SCALE*kp*e + KD_SCALE*kd*de + ki*sum) / OUT_DIVISOR.
  localparam logic signed [OPB_W-1:0] KP_SCALE    = 17'sd200;
  localparam logic signed [OPB_W-1:0] KD_SCALE    = 17'sd40000;
  localparam logic [DATA_W-1:0]       OUT_DIVISOR = 16'd51200;

  // Configuration register reset values.
  localparam logic [DATA_W-1:0]        DEPTH_SAT_RST = 16'd4000;
  localparam logic [TOL_W-1:0]         STOP_TOL_RST  = 15'd1638;
  localparam logic signed [DATA_W-1:0] KP_RST        = 16'sd256;
  localparam logic signed [DATA_W-1:0] KI_RST        = 16'sd0;
  localparam logic signed [DATA_W-1:0] KD_RST        = 16'sd0;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DEPTH_SAT = 3'd0,
    CFG_STOP_TOL  = 3'd1,
    CFG_STEER_KP  = 3'd2,
    CFG_STEER_KI  = 3'd3,
    CFG_STEER_KD  = 3'd4,
    CFG_DRIVE_KP  = 3'd5,
    CFG_DRIVE_KI  = 3'd6,
    CFG_DRIVE_KD  = 3'd7
  } cfg_idx_e;

  // Multiplier operand select and accumulator operation.
  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_OPS  = 2'd1,
    MUL_PROD = 2'd2
  } mul_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef struct packed {
    mul_op_e mul_op;
    acc_op_e acc_op;
  } mac_ctl_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  num;
    logic [DATA_W-1:0]        den;
  } div_req_t;

endpackage

@@ hdl/dpsd_mac.sv @@
// Shared multiply-accumulate unit: one registered signed multiplier and an accumulator.
// Depends on dpsd_pkg for widths and the control struct.
module dpsd_mac (
  input  logic                                  clk_i,
  input  dpsd_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [dpsd_pkg::OPA_W-1:0]     a_i,
  input  logic signed [dpsd_pkg::OPB_W-1:0]     b_i,
  output logic signed [dpsd_pkg::ACC_W-1:0]     acc_o
);

  logic signed [dpsd_pkg::ACC_W-1:0] prod_q;
  logic signed [dpsd_pkg::ACC_W-1:0] acc_q;
  logic signed [dpsd_pkg::OPA_W-1:0] mul_a;
  logic signed [dpsd_pkg::ACC_W-1:0] prod_d;

  // The first operand is either the input or the previous product, so a
  // product can be scaled by a constant in the next cycle.
  assign mul_a  = (ctl_i.mul_op == dpsd_pkg::MUL_PROD) ?
                  $signed(prod_q[dpsd_pkg::OPA_W-1:0]) : a_i;
  assign prod_d = mul_a * b_i;

  // Product register.
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.mul_op)
      dpsd_pkg::MUL_OPS,
      dpsd_pkg::MUL_PROD: prod_q <= prod_d;
      default:            prod_q <= prod_q;
    endcase
  end

  // Accumulator takes the registered product.
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.acc_op)
      dpsd_pkg::ACC_LOAD: acc_q <= prod_q;
      dpsd_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      default:            acc_q <= acc_q;
    endcase
  end

  assign acc_o = acc_q;

endmodule

@@ hdl/dpsd_div.sv @@
// Shared restoring divider: signed dividend over unsigned divisor, floor quotient
// saturated to 16 bit signed, one quotient bit per cycle. Depends on dpsd_pkg.
module dpsd_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dpsd_pkg::div_req_t                   req_i,
  output logic                                 done_o,
  output logic signed [dpsd_pkg::DATA_W-1:0]   quo_o
);

  localparam int unsigned CNT_W = $clog2(dpsd_pkg::DATA_W);

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_CHK  = 4'b0010,
    DV_STEP = 4'b0100,
    DV_FIX  = 4'b1000
  } div_state_e;

  div_state_e                         state_q, state_d;
  logic                               done_q, done_d;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;
  logic [dpsd_pkg::ACC_W-1:0]         mag_q, mag_d;
  logic                               neg_q, neg_d;
  logic [dpsd_pkg::DATA_W-1:0]        den_q, den_d;
  logic [dpsd_pkg::DATA_W:0]          rem_q, rem_d;
  logic [dpsd_pkg::DATA_W-1:0]        low_q, low_d;
  logic signed [dpsd_pkg::DATA_W-1:0] quo_q, quo_d;

  logic [dpsd_pkg::ACC_W-1:0]         limit;
  logic [dpsd_pkg::DATA_W:0]          trial;
  logic                               fits;
  logic [dpsd_pkg::DATA_W:0]          qfix;

  // Quotient magnitude stays within 2^15 exactly when the dividend
  // magnitude is within divisor * 2^15.
  assign limit = {{(dpsd_pkg::ACC_W - dpsd_pkg::DATA_W - dpsd_pkg::FRAC_W){1'b0}},
                  den_q, {dpsd_pkg::FRAC_W{1'b0}}};
  assign trial = {rem_q[dpsd_pkg::DATA_W-1:0], low_q[dpsd_pkg::DATA_W-1]};
  assign fits  = (trial >= {1'b0, den_q});
  assign qfix  = {1'b0, low_q} + {{dpsd_pkg::DATA_W{1'b0}}, (rem_q != '0)};

  // Sequencing of one division.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    den_d   = den_q;
    rem_d   = rem_q;
    low_d   = low_q;
    quo_d   = quo_q;
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          neg_d   = req_i.num[dpsd_pkg::ACC_W-1];
          mag_d   = req_i.num[dpsd_pkg::ACC_W-1] ? (~req_i.num + 1'b1) : req_i.num;
          den_d   = req_i.den;
          state_d = DV_CHK;
        end
      end
      DV_CHK: begin
        if (!neg_q && (mag_q >= limit)) begin
          quo_d   = 16'sh7FFF;
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end else if (neg_q && (mag_q > limit)) begin
          quo_d   = 16'sh8000;
          done_d  = 1'b1;
          state_d = DV_IDLE;
        end else begin
          rem_d   = {1'b0, mag_q[2*dpsd_pkg::DATA_W-1:dpsd_pkg::DATA_W]};
          low_d   = mag_q[dpsd_pkg::DATA_W-1:0];
          cnt_d   = '0;
          state_d = DV_STEP;
        end
      end
      DV_STEP: begin
        rem_d = fits ? (trial - {1'b0, den_q}) : trial;
        low_d = {low_q[dpsd_pkg::DATA_W-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(dpsd_pkg::DATA_W - 1)) begin
          state_d = DV_FIX;
        end
      end
      DV_FIX: begin
        // Round toward minus infinity for a negative dividend.
        quo_d   = neg_q ? $signed(qfix[dpsd_pkg::DATA_W-1:0] ^ {dpsd_pkg::DATA_W{1'b1}})
                          + 16'sd1
                        : $signed(low_q);
        done_d  = 1'b1;
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ hdl/dual_pid_steer_drive_controller.sv @@
// Top level of the dual PID steer and drive controller: registers, state and sequencer.
// Depends on dpsd_pkg, dpsd_mac and dpsd_div.
//
//   Channel   Direction  Handshake             Payload
//   in        request    in_valid/in_ready     target_column, target_depth
//   out       result     out_valid/out_ready   steer_command, drive_command, at_target
//   cfg       write      cfg_we                cfg_idx, cfg_wdata
//
// One request runs from acceptance to result through four quotients on the shared
// divider (two errors and two loop outputs, with 16 bit steps, none when the quotient
// saturates), the integral update, the multiplier program S_P1 to S_P6 for each of
// the two loops and the commit. in_ready is high only while the
// sequencer is idle and no finished tick waits to commit. A finished tick waits
// until the output register is free; while its result waits there, the next
// request is taken. Reset clears all loop state and loads the register defaults.
module dual_pid_steer_drive_controller #(
  parameter int unsigned CENTER_COLUMN        = dpsd_pkg::CENTER_COLUMN_DEF,
  parameter int unsigned INTEGRAL_RESET_LIMIT = dpsd_pkg::INTEGRAL_RESET_LIMIT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [dpsd_pkg::DATA_W-1:0]   target_column_i,
  input  logic signed [dpsd_pkg::DATA_W-1:0]   target_depth_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [dpsd_pkg::DATA_W-1:0]   steer_command_o,
  output logic signed [dpsd_pkg::DATA_W-1:0]   drive_command_o,
  output logic                                 at_target_o,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [dpsd_pkg::DATA_W-1:0]          cfg_wdata_i
);

  localparam int unsigned DW = dpsd_pkg::DATA_W;
  localparam int unsigned IW = dpsd_pkg::INT_W;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ERRA  = 14'b00000000000010,
    S_WAITA = 14'b00000000000100,
    S_ERRD  = 14'b00000000001000,
    S_WAITD = 14'b00000000010000,
    S_INTEG = 14'b00000000100000,
    S_P1    = 14'b00000001000000,
    S_P2    = 14'b00000010000000,
    S_P3    = 14'b00000100000000,
    S_P4    = 14'b00001000000000,
    S_P5    = 14'b00010000000000,
    S_P6    = 14'b00100000000000,
    S_PDIV  = 14'b01000000000000,
    S_PWAIT = 14'b10000000000000
  } seq_state_e;

  // Configuration registers.
  logic [DW-1:0]                 depth_sat_q;
  logic [dpsd_pkg::TOL_W-1:0]    stop_tol_q;
  logic signed [DW-1:0]          steer_kp_q, steer_ki_q, steer_kd_q;
  logic signed [DW-1:0]          drive_kp_q, drive_ki_q, drive_kd_q;

  // Loop state.
  logic signed [DW-1:0]          prev_steer_q, prev_drive_q;
  logic signed [IW-1:0]          steer_int_q, drive_int_q;
  logic [dpsd_pkg::TICK_W-1:0]   tick_q;

  // Sequencer and working registers.
  seq_state_e                    state_q, state_d;
  logic                          lane_q;
  logic                          fin_q;
  logic signed [DW-1:0]          col_q, depth_q;
  logic signed [DW-1:0]          ea_q, ed_q;
  logic signed [DW-1:0]          steer_q;

  // Output register.
  logic                          out_valid_q;
  logic signed [DW-1:0]          steer_out_q, drive_out_q;
  logic                          at_target_q;

  // Unit connections.
  dpsd_pkg::mac_ctl_t                  mac_ctl;
  logic signed [dpsd_pkg::OPA_W-1:0]   mac_a;
  logic signed [dpsd_pkg::OPB_W-1:0]   mac_b;
  logic signed [dpsd_pkg::ACC_W-1:0]   mac_acc;
  dpsd_pkg::div_req_t                  div_req;
  logic                                div_done;
  logic signed [DW-1:0]                div_quo;

  logic [DW-1:0]                 satd;
  logic signed [DW:0]            depth_clamp;
  logic signed [DW:0]            col_off;
  logic signed [IW:0]            steer_sum, drive_sum;
  logic signed [IW-1:0]          steer_sat, drive_sat;
  logic signed [DW-1:0]          cur_e, cur_prev, cur_kp, cur_ki, cur_kd;
  logic signed [IW-1:0]          cur_int;
  logic signed [DW:0]            cur_diff;
  logic                          stop;
  logic                          int_clear;
  logic                          out_free;
  logic                          in_acc;

  assign in_ready_o = (state_q == S_IDLE) && !fin_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Error numerators: zero saturation depth acts as one, depth clamps from above.
  assign satd        = (depth_sat_q == '0) ? 16'd1 : depth_sat_q;
  assign depth_clamp = ($signed({depth_q[DW-1], depth_q}) > $signed({1'b0, satd})) ?
                       $signed({1'b0, satd}) : $signed({depth_q[DW-1], depth_q});
  assign col_off     = $signed({col_q[DW-1], col_q}) - $signed((DW+1)'(CENTER_COLUMN));

  // Integral update with 32 bit saturation.
  assign steer_sum = $signed({steer_int_q[IW-1], steer_int_q})
                   + $signed({{(IW-DW+1){ea_q[DW-1]}}, ea_q});
  assign drive_sum = $signed({drive_int_q[IW-1], drive_int_q})
                   + $signed({{(IW-DW+1){ed_q[DW-1]}}, ed_q});
  assign steer_sat = (steer_sum[IW] != steer_sum[IW-1]) ?
                     {steer_sum[IW], {(IW-1){~steer_sum[IW]}}} : steer_sum[IW-1:0];
  assign drive_sat = (drive_sum[IW] != drive_sum[IW-1]) ?
                     {drive_sum[IW], {(IW-1){~drive_sum[IW]}}} : drive_sum[IW-1:0];

  // Operands of the loop currently in work.
  assign cur_e    = lane_q ? ed_q         : ea_q;
  assign cur_prev = lane_q ? prev_drive_q : prev_steer_q;
  assign cur_int  = lane_q ? drive_int_q  : steer_int_q;
  assign cur_kp   = lane_q ? drive_kp_q   : steer_kp_q;
  assign cur_ki   = lane_q ? drive_ki_q   : steer_ki_q;
  assign cur_kd   = lane_q ? drive_kd_q   : steer_kd_q;
  assign cur_diff = $signed({cur_e[DW-1], cur_e}) - $signed({cur_prev[DW-1], cur_prev});

  assign stop      = $signed({ed_q[DW-1], ed_q}) < $signed({2'b00, stop_tol_q});
  assign int_clear = tick_q > dpsd_pkg::TICK_W'(INTEGRAL_RESET_LIMIT);

  // Sequencer: next state, multiplier program and divider requests.
  always_comb begin
    state_d        = state_q;
    mac_ctl.mul_op = dpsd_pkg::MUL_NONE;
    mac_ctl.acc_op = dpsd_pkg::ACC_HOLD;
    mac_a          = '0;
    mac_b          = '0;
    div_req.start  = 1'b0;
    div_req.num    = '0;
    div_req.den    = satd;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_ERRA;
        end
      end
      S_ERRA: begin
        div_req.start = 1'b1;
        div_req.num   = dpsd_pkg::ACC_W'($signed({col_off, {dpsd_pkg::FRAC_W{1'b0}}}));
        div_req.den   = DW'(CENTER_COLUMN);
        state_d       = S_WAITA;
      end
      S_WAITA: begin
        if (div_done) begin
          state_d = S_ERRD;
        end
      end
      S_ERRD: begin
        div_req.start = 1'b1;
        div_req.num   = dpsd_pkg::ACC_W'($signed({depth_clamp, {dpsd_pkg::FRAC_W{1'b0}}}));
        state_d       = S_WAITD;
      end
      S_WAITD: begin
        if (div_done) begin
          state_d = S_INTEG;
        end
      end
      S_INTEG: state_d = S_P1;
      S_P1: begin
        mac_ctl.mul_op = dpsd_pkg::MUL_OPS;
        mac_a          = dpsd_pkg::OPA_W'(cur_e);
        mac_b          = dpsd_pkg::OPB_W'(cur_kp);
        state_d        = S_P2;
      end
      S_P2: begin
        mac_ctl.mul_op = dpsd_pkg::MUL_PROD;
        mac_b          = dpsd_pkg::KP_SCALE;
        state_d        = S_P3;
      end
      S_P3: begin
        mac_ctl.acc_op = dpsd_pkg::ACC_LOAD;
        mac_ctl.mul_op = dpsd_pkg::MUL_OPS;
        mac_a          = dpsd_pkg::OPA_W'(cur_diff);
        mac_b          = dpsd_pkg::OPB_W'(cur_kd);
        state_d        = S_P4;
      end
      S_P4: begin
        mac_ctl.mul_op = dpsd_pkg::MUL_PROD;
        mac_b          = dpsd_pkg::KD_SCALE;
        state_d        = S_P5;
      end
      S_P5: begin
        mac_ctl.acc_op = dpsd_pkg::ACC_ADD;
        mac_ctl.mul_op = dpsd_pkg::MUL_OPS;
        mac_a          = dpsd_pkg::OPA_W'(cur_int);
        mac_b          = dpsd_pkg::OPB_W'(cur_ki);
        state_d        = S_P6;
      end
      S_P6: begin
        mac_ctl.acc_op = dpsd_pkg::ACC_ADD;
        state_d        = S_PDIV;
      end
      S_PDIV: begin
        div_req.start = 1'b1;
        div_req.num   = mac_acc;
        div_req.den   = dpsd_pkg::OUT_DIVISOR;
        state_d       = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_done) begin
          state_d = lane_q ? S_IDLE : S_P1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer control registers; fin_q marks a finished tick waiting to commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lane_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_INTEG) begin
        lane_q <= 1'b0;
      end else if ((state_q == S_PWAIT) && div_done) begin
        lane_q <= 1'b1;
      end
      if ((state_q == S_PWAIT) && div_done && lane_q) begin
        fin_q <= 1'b1;
      end else if (fin_q && out_free) begin
        fin_q <= 1'b0;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q   <= target_column_i;
      depth_q <= target_depth_i;
    end
    if ((state_q == S_WAITA) && div_done) begin
      ea_q <= div_quo;
    end
    if ((state_q == S_WAITD) && div_done) begin
      ed_q <= div_quo;
    end
    if ((state_q == S_PWAIT) && div_done && !lane_q) begin
      steer_q <= div_quo;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_sat_q <= dpsd_pkg::DEPTH_SAT_RST;
      stop_tol_q  <= dpsd_pkg::STOP_TOL_RST;
      steer_kp_q  <= dpsd_pkg::KP_RST;
      steer_ki_q  <= dpsd_pkg::KI_RST;
      steer_kd_q  <= dpsd_pkg::KD_RST;
      drive_kp_q  <= dpsd_pkg::KP_RST;
      drive_ki_q  <= dpsd_pkg::KI_RST;
      drive_kd_q  <= dpsd_pkg::KD_RST;
    end else if (cfg_we_i) begin
      unique case (dpsd_pkg::cfg_idx_e'(cfg_idx_i))
        dpsd_pkg::CFG_DEPTH_SAT: depth_sat_q <= cfg_wdata_i;
        dpsd_pkg::CFG_STOP_TOL:  stop_tol_q  <= cfg_wdata_i[dpsd_pkg::TOL_W-1:0];
        dpsd_pkg::CFG_STEER_KP:  steer_kp_q  <= $signed(cfg_wdata_i);
        dpsd_pkg::CFG_STEER_KI:  steer_ki_q  <= $signed(cfg_wdata_i);
        dpsd_pkg::CFG_STEER_KD:  steer_kd_q  <= $signed(cfg_wdata_i);
        dpsd_pkg::CFG_DRIVE_KP:  drive_kp_q  <= $signed(cfg_wdata_i);
        dpsd_pkg::CFG_DRIVE_KI:  drive_ki_q  <= $signed(cfg_wdata_i);
        dpsd_pkg::CFG_DRIVE_KD:  drive_kd_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Loop state: integrals grow after both errors are known, then the tick
  // commit applies the periodic clear, the stop clear and the tick count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_steer_q <= '0;
      prev_drive_q <= '0;
      steer_int_q  <= '0;
      drive_int_q  <= '0;
      tick_q       <= '0;
    end else if (state_q == S_INTEG) begin
      steer_int_q <= steer_sat;
      drive_int_q <= drive_sat;
    end else if (fin_q && out_free) begin
      prev_steer_q <= ea_q;
      prev_drive_q <= ed_q;
      if (int_clear) begin
        steer_int_q <= '0;
        tick_q      <= dpsd_pkg::TICK_W'(1);
      end else begin
        tick_q <= tick_q + 1'b1;
      end
      // The drive integral clears on the periodic clear and whenever the target is reached.
      if (int_clear || stop) begin
        drive_int_q <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q && out_free) begin
      steer_out_q <= steer_q;
      drive_out_q <= stop ? '0 : div_quo;
      at_target_q <= stop;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign steer_command_o = steer_out_q;
  assign drive_command_o = drive_out_q;
  assign at_target_o     = at_target_q;

  // Shared arithmetic units.
  dpsd_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (mac_acc)
  );

  dpsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

endmodule
